### sv/height_to_normal_map_top_assert.svh
// Assertion macros used by the height to normal map top level.
`ifndef HEIGHT_TO_NORMAL_MAP_TOP_ASSERT_SVH
`define HEIGHT_TO_NORMAL_MAP_TOP_ASSERT_SVH
// Same-cycle implication, checked on every rising edge outside reset.
`define HNM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define HNM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### sv/hnm_pkg.sv
// Types and constants shared by the height to normal map modules.
package hnm_pkg;
  localparam int EFF_W_BITS = 14;
  localparam int EFF_H_BITS = 17;
  localparam logic [17:0] D_BIAS = 18'd65025;
  localparam logic [29:0] SQ_BLUE = 30'd1065369600;
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_DRAIN = 1'b1;
  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_CALC
  } hnm_state_t;

  typedef enum logic [1:0] {
    U_IDLE, U_SQ, U_MUL, U_DONE
  } hnm_ustate_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hnm_res_t;
endpackage

### sv/hnm_ram.sv
// Generic single-port RAM with registered read.
module hnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                        wdata,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### sv/hnm_normal.sv
// Iterative normal unit: bit-wise search of floor(num / sqrt(d)) per channel.
module hnm_normal (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [7:0]       h,
  input  logic [7:0]       right,
  input  logic [7:0]       nxt,
  input  logic             ack,
  output logic             busy,
  output hnm_pkg::hnm_res_t res
);
  hnm_pkg::hnm_ustate_t ust, ust_next;
  logic [17:0] d;
  logic [29:0] sq_r, sq_g;
  logic        neg_r, neg_g;
  logic [1:0]  ch;
  logic [2:0]  bitpos;
  logic [7:0]  t;
  logic [16:0] qq;
  logic [7:0]  red, green, blue;

  logic signed [8:0] da, db;
  logic [7:0]  ma, mb;
  logic [15:0] aa, bb;
  logic [7:0]  cand;
  logic [8:0]  q;
  logic [34:0] prod;
  logic [29:0] sq_cur;
  logic        neg_cur, pass, last_bit;
  logic [7:0]  tf, tmin, val;
  logic [8:0]  psum;

  always_comb begin
    da = $signed({1'b0, h}) - $signed({1'b0, right});
    db = $signed({1'b0, h}) - $signed({1'b0, nxt});
    ma = da[8] ? 8'(-da) : da[7:0];
    mb = db[8] ? 8'(-db) : db[7:0];
    aa = ma * ma;
    bb = mb * mb;
    case (ch)
      2'd0:    begin sq_cur = sq_r; neg_cur = neg_r; end
      2'd1:    begin sq_cur = sq_g; neg_cur = neg_g; end
      default: begin sq_cur = hnm_pkg::SQ_BLUE; neg_cur = 1'b0; end
    endcase
    cand = t | (8'd1 << bitpos);
    // Positive: largest t with t*t*d <= sq. Negative: largest t with t*t*d < sq.
    q = {1'b0, cand};
    prod = 35'(qq) * 35'(d);
    pass = neg_cur ? (prod < 35'(sq_cur)) : (prod <= 35'(sq_cur));
    last_bit = (bitpos == 3'd0);
    tf = pass ? cand : t;
    psum = 9'd128 + {1'b0, tf};
    tmin = (tf == 8'd255) ? 8'd255 : tf + 8'd1;
    if (neg_cur) begin
      val = (tmin > 8'd128) ? 8'd0 : 8'(8'd128 - tmin);
    end else begin
      val = psum[8] ? 8'd255 : psum[7:0];
    end
  end

  always_comb begin
    ust_next = ust;
    case (ust)
      hnm_pkg::U_IDLE: if (start) ust_next = hnm_pkg::U_SQ;
      hnm_pkg::U_SQ:   ust_next = hnm_pkg::U_MUL;
      hnm_pkg::U_MUL: begin
        if (last_bit && ch == 2'd2) ust_next = hnm_pkg::U_DONE;
        else ust_next = hnm_pkg::U_SQ;
      end
      hnm_pkg::U_DONE: if (ack) ust_next = hnm_pkg::U_IDLE;
      default:         ust_next = hnm_pkg::U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ust <= hnm_pkg::U_IDLE;
    end else begin
      ust <= ust_next;
    end
  end

  always_ff @(posedge clk) begin
    case (ust)
      hnm_pkg::U_IDLE: begin
        d <= 18'(aa) + 18'(bb) + hnm_pkg::D_BIAS;
        sq_r <= {aa, 14'd0};
        sq_g <= {bb, 14'd0};
        neg_r <= da[8];
        neg_g <= !db[8] && (db != 9'sd0);
        ch <= 2'd0;
        bitpos <= 3'd7;
        t <= 8'd0;
      end
      hnm_pkg::U_SQ: qq <= q * q;
      hnm_pkg::U_MUL: begin
        if (last_bit) begin
          case (ch)
            2'd0:    red <= val;
            2'd1:    green <= val;
            default: blue <= val;
          endcase
          ch <= ch + 2'd1;
          t <= 8'd0;
        end else begin
          t <= tf;
        end
        bitpos <= bitpos - 3'd1;
      end
      default: ;
    endcase
  end

  assign busy = (ust != hnm_pkg::U_IDLE);
  assign res = '{valid: (ust == hnm_pkg::U_DONE), red: red, green: green, blue: blue};
endmodule

### sv/height_to_normal_map_top.sv
// Height map to normal map converter: top level with row store and sequencer.
// An accepted item passes the row store reads (S_RD0, S_RD1, S_RD2), then the shared
// multiply-compare search (U_SQ and U_MUL per bit, three channels), then the hand-off.
// A new item is taken only once the last is through: after the hand-off when it gives a
// result, after S_RD2 for a first-row sample, and at once for an ignored item.
// Reset (rst, sync) clears positions, draining and output; row store kept, size 1024x1024.
module height_to_normal_map_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream. s_tdata: height_sample[7:0]. s_tuser: op (1 means drain).
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  // Output stream. m_tdata: normal_red[7:0], normal_green[15:8], normal_blue[23:16],
  // pixel_column[33:24], pixel_row[45:34], zero fill[47:46]. m_tlast: frame_done.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,
  output logic        m_tlast,
  // Configuration writes: index 0 image_width, index 1 image_height.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EWB = hnm_pkg::EFF_W_BITS;
  localparam int EHB = hnm_pkg::EFF_H_BITS;

  // Configuration registers.
  logic [10:0] image_width;
  logic [12:0] image_height;

  // Position state of the raster walk.
  logic [9:0]  column_position;
  logic [12:0] row_position;
  logic        draining;

  // The item in flight.
  hnm_pkg::hnm_state_t state, state_next;
  logic        cur_op;
  logic [7:0]  cur_sample;
  logic [7:0]  h_val;
  logic        emit;
  logic [9:0]  res_col;
  logic [11:0] res_row;
  logic        res_last;

  // Position of the item in the normal unit, held until its result is taken.
  logic [9:0]  hold_col;
  logic [11:0] hold_row;
  logic        hold_last;

  // Output register.
  logic        out_valid;
  logic [7:0]  out_red, out_green, out_blue;
  logic [9:0]  out_col;
  logic [11:0] out_row;
  logic        out_last;

  logic [EWB-1:0] eff_w, col_inc;
  logic [EHB-1:0] eff_h, row_inc;
  logic        last_col, accept, ignore_item, start, ack, busy;
  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]  ram_rdata;
  logic [7:0]  right_val;
  hnm_pkg::hnm_res_t res;

  // Register values out of range are clamped to 1..MAX.
  always_comb begin
    if (image_width == 11'd0) eff_w = EWB'(1);
    else if (int'(image_width) > MAX_WIDTH) eff_w = EWB'(MAX_WIDTH);
    else eff_w = EWB'(image_width);
    if (image_height == 13'd0) eff_h = EHB'(1);
    else if (int'(image_height) > MAX_HEIGHT) eff_h = EHB'(MAX_HEIGHT);
    else eff_h = EHB'(image_height);
    col_inc = EWB'(column_position) + EWB'(1);
    row_inc = EHB'(row_position) + EHB'(1);
    last_col = (col_inc >= eff_w);
  end

  assign s_tready = (state == hnm_pkg::S_IDLE);
  assign accept = s_tvalid && s_tready;
  // A sample during draining and a drain tick outside it are dropped at once.
  assign ignore_item = (s_tuser == hnm_pkg::OP_SAMPLE) ? draining : !draining;
  assign ack = (state == hnm_pkg::S_CALC) && res.valid && (!out_valid || m_tready);

  always_comb begin
    state_next = state;
    case (state)
      hnm_pkg::S_IDLE: if (accept && !ignore_item) state_next = hnm_pkg::S_RD0;
      hnm_pkg::S_RD0:  state_next = hnm_pkg::S_RD1;
      hnm_pkg::S_RD1:  state_next = hnm_pkg::S_RD2;
      hnm_pkg::S_RD2:  state_next = emit ? hnm_pkg::S_CALC : hnm_pkg::S_IDLE;
      hnm_pkg::S_CALC: if (ack) state_next = hnm_pkg::S_IDLE;
      default:         state_next = hnm_pkg::S_IDLE;
    endcase
  end

  // Row store control: read the pixel, then its right neighbor, then for a
  // sample write the new sample back over the pixel.
  always_comb begin
    ram_we = 1'b0;
    ram_addr = AW'(column_position);
    start = 1'b0;
    case (state)
      hnm_pkg::S_RD1: ram_addr = AW'(col_inc);
      hnm_pkg::S_RD2: begin
        ram_we = (cur_op == hnm_pkg::OP_SAMPLE);
        start = emit;
      end
      default: ;
    endcase
  end

  // Emit decision for the item that reaches the last read cycle.
  always_comb begin
    if (cur_op == hnm_pkg::OP_SAMPLE) begin
      emit = (row_position != 13'd0);
      res_row = 12'(row_position - 13'd1);
      res_last = 1'b0;
    end else begin
      emit = 1'b1;
      res_row = 12'(eff_h - EHB'(1));
      res_last = last_col;
    end
    res_col = column_position;
    right_val = last_col ? h_val : ram_rdata;
  end

  hnm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cur_sample),
    .rdata (ram_rdata)
  );

  hnm_normal u_normal (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .h     (h_val),
    .right (right_val),
    .nxt   ((cur_op == hnm_pkg::OP_SAMPLE) ? cur_sample : h_val),
    .ack   (ack),
    .busy  (busy),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hnm_pkg::S_IDLE;
      image_width <= 11'd1024;
      image_height <= 13'd1024;
      column_position <= 10'd0;
      row_position <= 13'd0;
      draining <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == hnm_pkg::CFG_WIDTH) image_width <= cfg_data[10:0];
        else image_height <= cfg_data;
      end
      // Positions advance once per item, in the cycle of the write back.
      if (state == hnm_pkg::S_RD2) begin
        if (last_col) begin
          column_position <= 10'd0;
          if (cur_op == hnm_pkg::OP_SAMPLE) begin
            if (row_inc >= eff_h) begin
              row_position <= 13'd0;
              draining <= 1'b1;
            end else begin
              row_position <= row_inc[12:0];
            end
          end else begin
            draining <= 1'b0;
          end
        end else begin
          column_position <= col_inc[9:0];
        end
      end
      if (ack) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op <= s_tuser;
      cur_sample <= s_tdata;
    end
    if (state == hnm_pkg::S_RD1) h_val <= ram_rdata;
    // The output register may still hold an earlier result here, so the
    // position waits beside the normal unit until the hand-off.
    if (state == hnm_pkg::S_RD2) begin
      hold_col <= res_col;
      hold_row <= res_row;
      hold_last <= res_last;
    end
    if (ack) begin
      out_red <= res.red;
      out_green <= res.green;
      out_blue <= res.blue;
      out_col <= hold_col;
      out_row <= hold_row;
      out_last <= hold_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {2'b00, out_row, out_col, out_blue, out_green, out_red};
  assign m_tlast = out_last;

`include "height_to_normal_map_top_assert.svh"
  // Draining always starts from row zero, and samples cannot move the row then.
  `HNM_ASSERT_IMP(a_drain_row, draining, row_position == 13'd0, "row moved while draining")
  // A result is taken from the normal unit only when it has one.
  `HNM_ASSERT_IMP(a_ack_valid, ack, res.valid, "result taken from an idle normal unit")
  // The normal unit is never restarted while a search is running.
  `HNM_ASSERT_NXT(a_start_busy, start, busy && !start, "normal unit restarted while busy")
endmodule

### bench/normal_map_checker.sv
// Checker for the height to normal map: predicts each normal and compares it with the output.
`timescale 1ns / 1ps
module normal_map_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  output int          errors,
  output int          pending
);
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [9:0]  column;
    logic [11:0] row;
    logic        done;
  } normal_t;

  normal_t     normals_due[$];
  logic [10:0] width_reg;
  logic [12:0] height_reg;
  logic [7:0]  prev_row [0:1023];
  int unsigned col_pos;
  int unsigned row_pos;
  bit          draining;

  assign pending = normals_due.size();

  // Exact floor(num / sqrt(d)), by a linear search up from zero in both signs.
  function automatic int root_div(int num, longint d);
    longint mag, sq, t;
    mag = (num < 0) ? -num : num;
    sq = mag * mag;
    t = 0;
    if (num >= 0) begin
      while (t < 255 && (t + 1) * (t + 1) * d <= sq) t++;
      return int'(t);
    end
    while (t < 255 && t * t * d < sq) t++;
    return -int'(t);
  endfunction

  function automatic logic [7:0] clip255(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic normal_t shade(int h, int right, int next);
    normal_t n;
    int a, b;
    longint d;
    a = h - right;
    b = h - next;
    d = a * a + b * b + 65025;
    n = '0;
    n.red = clip255(128 + root_div(128 * a, d));
    n.green = clip255(128 + root_div(-128 * b, d));
    n.blue = clip255(128 + root_div(32640, d));
    return n;
  endfunction

  task automatic predict(logic op, logic [7:0] sample);
    int unsigned w, hg, col;
    bit last_col;
    int h, right;
    normal_t n;
    w = (width_reg == 0) ? 1 : (width_reg > 1024 ? 1024 : width_reg);
    hg = (height_reg == 0) ? 1 : (height_reg > 4096 ? 4096 : height_reg);
    col = col_pos;
    last_col = (col + 1 >= w);
    h = prev_row[col];
    right = last_col ? h : ((col + 1 < 1024) ? int'(prev_row[col + 1]) : 0);
    if (op == hnm_pkg::OP_SAMPLE) begin
      // Samples are ignored while the last row drains.
      if (draining) return;
      if (row_pos >= 1) begin
        n = shade(h, right, sample);
        n.column = col[9:0];
        n.row = 12'(row_pos - 1);
        n.done = 1'b0;
        normals_due.push_back(n);
      end
      prev_row[col] = sample;
      if (last_col) begin
        col_pos = 0;
        if (row_pos + 1 >= hg) begin
          row_pos = 0;
          draining = 1;
        end else begin
          row_pos = row_pos + 1;
        end
      end else begin
        col_pos = col + 1;
      end
    end else begin
      if (!draining) return;
      // The last row is its own next row.
      n = shade(h, right, h);
      n.column = col[9:0];
      n.row = 12'(hg - 1);
      n.done = last_col;
      normals_due.push_back(n);
      if (last_col) begin
        col_pos = 0;
        draining = 0;
      end else begin
        col_pos = col + 1;
      end
    end
  endtask

  task automatic report(string what, int exp_v, int act_v);
    errors++;
    if (errors <= 10)
      $display("mismatch in %s: expected %0d, got %0d", what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    normal_t want;
    if (rst) begin
      width_reg = 11'd1024;
      height_reg = 13'd1024;
      col_pos = 0;
      row_pos = 0;
      draining = 0;
      normals_due.delete();
      for (int i = 0; i < 1024; i++) prev_row[i] = 8'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == hnm_pkg::CFG_WIDTH) width_reg = cfg_data[10:0];
        else height_reg = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        if (normals_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected normal: %h last %b", m_tdata, m_tlast);
        end else begin
          want = normals_due.pop_front();
          if (m_tdata[7:0] != want.red) report("red", want.red, m_tdata[7:0]);
          if (m_tdata[15:8] != want.green) report("green", want.green, m_tdata[15:8]);
          if (m_tdata[23:16] != want.blue) report("blue", want.blue, m_tdata[23:16]);
          if (m_tdata[33:24] != want.column) report("column", want.column, m_tdata[33:24]);
          if (m_tdata[45:34] != want.row) report("row", want.row, m_tdata[45:34]);
          if (m_tdata[47:46] != 2'b00) report("fill", 0, m_tdata[47:46]);
          if (m_tlast != want.done) report("frame_done", want.done, m_tlast);
        end
      end
      if (s_tvalid && s_tready) predict(s_tuser, s_tdata);
    end
  end
endmodule

### bench/testbench.sv
// Top of the height to normal map bench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = hnm_pkg::OP_SAMPLE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = hnm_pkg::CFG_WIDTH;
  logic [12:0] cfg_data = '0;
  int          errors;
  int          pending;

  // Idling is switched off for whole stretches of the run.
  bit          calm = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  int          sent = 0;

  localparam int WATCHDOG_LIMIT = 20000;

  always #5 clk = ~clk;

  height_to_normal_map_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  normal_map_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = int'($urandom_range(99));
    if (r < 65) return 0;
    if (r < 95) return int'($urandom_range(3, 1));
    return int'($urandom_range(120, 20));
  endfunction

  // The receiver stalls on its own schedule, changing only on falling edges.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (calm || $urandom_range(1) == 1) begin
      m_tready <= 1'b1;
      stall_left <= int'($urandom_range(6));
    end else begin
      m_tready <= 1'b0;
      stall_left <= gap_len();
    end
  end

  // The watchdog restarts on every accepted item in either direction.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Each call starts and ends on a falling edge; valid stays high across back-to-back items.
  task automatic send_item(logic op, logic [7:0] h);
    int g;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= h;
    do @(posedge clk); while (!s_tready);
    sent++;
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Hold the sender until every predicted normal has come out, then let the pipeline settle.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  // Registers are only touched with the block idle, between frames.
  task automatic set_size(logic [12:0] w, logic [12:0] h);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= hnm_pkg::CFG_WIDTH;
    cfg_data <= w;
    @(negedge clk);
    cfg_index <= hnm_pkg::CFG_HEIGHT;
    cfg_data <= h;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int clamp(logic [12:0] v, int top_v);
    if (v == 0) return 1;
    if (int'(v) > top_v) return top_v;
    return int'(v);
  endfunction

  // One whole frame; kind 0 random heights, 1 alternating extremes, 2 all zero, 3 all max.
  // Noise items of the wrong kind are mixed in and must be ignored.
  task automatic run_frame(logic [12:0] wr, logic [12:0] hr, int kind, bit noise);
    int w, h;
    logic [7:0] v;
    w = clamp({2'b00, wr[10:0]}, 1024);
    h = clamp(hr, 4096);
    set_size(wr, hr);
    for (int i = 0; i < w * h; i++) begin
      case (kind)
        0: v = 8'($urandom_range(255));
        1: v = ((i + i / w) % 2) ? 8'd255 : 8'd0;
        2: v = 8'd0;
        default: v = 8'd255;
      endcase
      if (noise && $urandom_range(15) == 0)
        send_item(hnm_pkg::OP_DRAIN, 8'($urandom_range(255)));
      // Once in a while the sender waits for the output to catch up mid-frame.
      if (noise && $urandom_range(199) == 0) settle();
      send_item(hnm_pkg::OP_SAMPLE, v);
    end
    for (int i = 0; i < w; i++) begin
      if (noise && $urandom_range(15) == 0)
        send_item(hnm_pkg::OP_SAMPLE, 8'($urandom_range(255)));
      send_item(hnm_pkg::OP_DRAIN, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    int w, h;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes of heights, single-row and single-column frames,
    // and a zero register value that clamps.
    run_frame(13'd2, 13'd2, 1, 0);
    run_frame(13'd3, 13'd2, 3, 1);
    run_frame(13'd0, 13'd0, 0, 1);
    run_frame(13'd4, 13'd1, 1, 1);
    run_frame(13'd1, 13'd3, 1, 0);
    run_frame(13'd2, 13'd3, 2, 1);

    // Random frames, mostly small with random content and some noise.
    while (sent < 1120) begin
      calm = ($urandom_range(3) == 0);
      if ($urandom_range(9) == 0) w = int'($urandom_range(64, 1));
      else w = int'($urandom_range(12, 1));
      h = int'($urandom_range(8, 1));
      if (w * (h + 1) > 1150 - sent) h = 1;
      run_frame(13'(w), 13'(h),
        ($urandom_range(7) == 0) ? int'($urandom_range(3, 1)) : 0, 1);
    end
    calm = 0;

    settle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

### height_to_normal_map_top.f
+incdir+sv
sv/hnm_pkg.sv
sv/hnm_ram.sv
sv/hnm_normal.sv
sv/height_to_normal_map_top.sv
bench/normal_map_checker.sv
bench/testbench.sv
